// ----- rtl/ffba_pkg.sv -----
// Shared constants and types for the first-fit bin allocator.
// No dependencies.
package ffba_pkg;
    localparam int NUM_BINS  = 1024;
    localparam int LOAD_BITS = 30;
    localparam int CNT_BITS  = 16;
    localparam int BIN_BITS  = 11;
    localparam int ADDR_BITS = $clog2(NUM_BINS);
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 30;

    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITEMS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BINS      = 2'd2;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic [LOAD_BITS-1:0] load;
    } bin_entry_t;
endpackage

// ----- rtl/first_fit_bin_allocator_top.sv -----
// First-fit bin allocator top level: config registers, scan sequencer, bin memory.
// Depends on ffba_pkg.
//
// An item is taken when start is high and busy is low; its result appears on
// placed and bin_number for one cycle with done high, and the receiver cannot
// stall it. A place item scans bin memory one entry per cycle from bin 1 and
// stops at the first bin that fits or after the last bin in use, as set by the
// bins register; with that count zero a place item answers straight from idle.
// A clear item sweeps all 1024 entries. After reset the same clearing pass
// runs with busy high. The user must write configuration only while no item
// is in flight, since the capacity is read throughout a scan; the block itself
// does not enforce this.
module first_fit_bin_allocator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic [ffba_pkg::LOAD_BITS-1:0]       item_size,
    output logic                                 done,
    output logic                                 placed,
    output logic [ffba_pkg::BIN_BITS-1:0]        bin_number,
    input  logic                                 cfg_we,
    input  logic [ffba_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ffba_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;
    localparam int AW = ffba_pkg::ADDR_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ffba_pkg::NUM_BINS - 1);

    logic [ffba_pkg::LOAD_BITS-1:0] capacity_reg;
    logic [ffba_pkg::CNT_BITS-1:0]  max_items_reg;
    logic [ffba_pkg::BIN_BITS-1:0]  bins_reg;

    logic [1:0]                     state_reg, state_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [ffba_pkg::LOAD_BITS-1:0] size_reg, size_next;
    logic [ffba_pkg::CNT_BITS-1:0]  limit_reg, limit_next;
    logic [ffba_pkg::BIN_BITS-1:0]  span_reg, span_next;
    logic                           done_reg, done_next;
    logic                           placed_reg, placed_next;
    logic [ffba_pkg::BIN_BITS-1:0]  bin_reg, bin_next;

    ffba_pkg::bin_entry_t mem [ffba_pkg::NUM_BINS];
    ffba_pkg::bin_entry_t rd_q;
    ffba_pkg::bin_entry_t wr_data;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;

    logic [ffba_pkg::LOAD_BITS:0] sum;
    logic                         fit;
    logic                         last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            max_items_reg <= ffba_pkg::CNT_BITS'(1);
            bins_reg      <= ffba_pkg::BIN_BITS'(ffba_pkg::NUM_BINS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffba_pkg::REG_CAPACITY:  capacity_reg  <= cfg_data;
                ffba_pkg::REG_MAX_ITEMS: max_items_reg <= cfg_data[ffba_pkg::CNT_BITS-1:0];
                ffba_pkg::REG_BINS:      bins_reg      <= cfg_data[ffba_pkg::BIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    assign sum  = {1'b0, rd_q.load} + {1'b0, size_reg};
    assign fit  = (rd_q.count < limit_reg) && (sum <= {1'b0, capacity_reg});
    assign last = ({{(ffba_pkg::BIN_BITS-AW){1'b0}}, idx_reg} + 1'b1) == span_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        limit_next  = limit_reg;
        span_next   = span_reg;
        done_next   = 1'b0;
        placed_next = 1'b0;
        bin_next    = '0;
        wr_en       = 1'b0;
        wr_data     = '0;
        rd_addr     = idx_reg + 1'b1;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                    done_next  = (state_reg == ST_CLEAR);
                end
            end
            ST_IDLE:
            begin
                rd_addr  = '0;
                idx_next = '0;
                if (start)
                begin
                    size_next  = item_size;
                    limit_next = (max_items_reg == '0) ? ffba_pkg::CNT_BITS'(1) : max_items_reg;
                    span_next  = (bins_reg > ffba_pkg::BIN_BITS'(ffba_pkg::NUM_BINS))
                               ? ffba_pkg::BIN_BITS'(ffba_pkg::NUM_BINS) : bins_reg;
                    if (opcode == ffba_pkg::OP_CLEAR)
                        state_next = ST_CLEAR;
                    else if (span_next == '0)
                        done_next = 1'b1;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (fit)
                begin
                    wr_en         = 1'b1;
                    wr_data.load  = sum[ffba_pkg::LOAD_BITS-1:0];
                    wr_data.count = rd_q.count + 1'b1;
                    done_next     = 1'b1;
                    placed_next   = 1'b1;
                    bin_next      = {{(ffba_pkg::BIN_BITS-AW){1'b0}}, idx_reg} + 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (last)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            placed_reg <= 1'b0;
            bin_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
            placed_reg <= placed_next;
            bin_reg    <= bin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        limit_reg <= limit_next;
        span_reg  <= span_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign placed     = placed_reg;
    assign bin_number = bin_reg;
endmodule

// ----- rtl/ffba_checker.sv -----
// Port-level assertions for the first-fit bin allocator, bound to the top level.
// Depends on ffba_pkg.
module ffba_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                opcode,
    input logic                                done,
    input logic                                placed,
    input logic [ffba_pkg::BIN_BITS-1:0]       bin_number
);
    a_bin_when_placed: assert property (@(posedge clk) disable iff (!rst_n)
        done && placed |-> bin_number != '0) else $error("placed without bin");
    a_zero_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
        done && !placed |-> bin_number == '0) else $error("bin without place");
    a_busy_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == ffba_pkg::OP_CLEAR |=> busy) else $error("clear not busy");
    a_place_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == ffba_pkg::OP_PLACE |=> busy || done)
        else $error("place item dropped");
endmodule

bind first_fit_bin_allocator_top ffba_checker u_ffba_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
    .done(done), .placed(placed), .bin_number(bin_number)
);
